// File: hw/rtl/rrts_pkg.sv
// Shared constants, codes and types of the round-robin task scheduler.
package rrts_pkg;

    localparam int USER_TASKS   = 7;
    localparam int SLOTS        = USER_TASKS + 1;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CUR_W        = $clog2(SLOTS + 1);
    localparam int CRT_W        = $clog2(USER_TASKS + 1);
    localparam int RUN_W        = 4;
    localparam int DATA_W       = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int Q_PTR_W      = 1;
    localparam int Q_CNT_W      = 2;

    localparam logic [CUR_W-1:0] NONE_STARTED = CUR_W'(SLOTS);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_DELAY  = 2'd1;
    localparam logic [1:0] CMD_SWITCH = 2'd2;
    localparam logic [1:0] CMD_CREATE = 2'd3;

    typedef logic [1:0] t_status;

    localparam t_status TS_UNUSED  = 2'd0;
    localparam t_status TS_READY   = 2'd1;
    localparam t_status TS_RUNNING = 2'd2;
    localparam t_status TS_BLOCKED = 2'd3;

    // A command after classification by the front end.
    typedef struct packed {
        logic              is_tick;
        logic              is_delay;
        logic              is_switch;
        logic              is_create;
        logic              ticks_nonzero;
        logic [DATA_W-1:0] ticks;
        logic [DATA_W-1:0] sp;
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] next_sp;
        logic [RUN_W-1:0]  running_task;
        logic              accepted;
    } t_res;

endpackage

// File: hw/rtl/rrts_front.sv
// Front end: accepts command items, classifies them and queues them for the back end.
module rrts_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [1:0]                 i_cmd,
    input  logic [rrts_pkg::DATA_W-1:0] i_delay_ticks,
    input  logic [rrts_pkg::DATA_W-1:0] i_stack_pointer,
    output logic                       o_op_valid,
    output rrts_pkg::t_op              o_op,
    input  logic                       i_op_take
);
    import rrts_pkg::*;

    t_op                r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               push_ok;
    logic               take_ok;
    t_op                op_in;

    assign o_full     = (r_cnt == Q_CNT_W'(QUEUE_DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_mem[r_rptr];
    assign push_ok    = i_push && !o_full;
    assign take_ok    = i_op_take && o_op_valid;

    always_comb begin
        op_in.is_tick       = (i_cmd == CMD_TICK);
        op_in.is_delay      = (i_cmd == CMD_DELAY);
        op_in.is_switch     = (i_cmd == CMD_SWITCH);
        op_in.is_create     = (i_cmd == CMD_CREATE);
        op_in.ticks_nonzero = (i_delay_ticks != '0);
        op_in.ticks         = i_delay_ticks;
        op_in.sp            = i_stack_pointer;
    end

    always_comb begin
        n_wptr = push_ok ? r_wptr + Q_PTR_W'(1) : r_wptr;
        n_rptr = take_ok ? r_rptr + Q_PTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + Q_CNT_W'(push_ok) - Q_CNT_W'(take_ok);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/rrts_back.sv
// Back end: task table, command execution, saved-pointer memory and result queue.
module rrts_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrts_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic                        i_op_valid,
    input  rrts_pkg::t_op               i_op,
    output logic                        o_op_take,
    output logic                        o_empty,
    input  logic                        i_pop,
    output rrts_pkg::t_res              o_res
);
    import rrts_pkg::*;

    localparam logic PH_RUN  = 1'b0;
    localparam logic PH_READ = 1'b1;

    logic               r_phase, n_phase;
    t_status            r_status [SLOTS];
    t_status            n_status [SLOTS];
    logic [DATA_W-1:0]  r_count  [SLOTS];
    logic [DATA_W-1:0]  n_count  [SLOTS];
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [CRT_W-1:0]   r_created, n_created;
    logic [DATA_W-1:0]  r_idle_sp;
    logic               r_bypass, n_bypass;
    logic [DATA_W-1:0]  r_sp_hold;

    // Saved stack pointers, one per slot.
    logic [DATA_W-1:0]  r_spmem [SLOTS];
    logic [DATA_W-1:0]  r_rd_data;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [SLOT_W-1:0]  mem_raddr;

    // Result queue.
    t_res               r_res [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_rcnt;
    logic               res_push;
    t_res               res_val;
    logic               pop_ok;

    logic               started;
    logic [SLOT_W-1:0]  cs;

    assign started   = (r_cur != NONE_STARTED);
    assign cs        = r_cur[SLOT_W-1:0];
    assign o_op_take = i_op_valid && (r_phase == PH_RUN) &&
                       (r_rcnt < Q_CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_rcnt == '0);
    assign o_res     = r_res[r_rptr];
    assign pop_ok    = i_pop && !o_empty;

    always_comb begin
        t_status           dem [SLOTS];
        logic              found;
        logic [SLOT_W-1:0] pick;
        logic [SLOT_W:0]   sum;
        logic [SLOT_W-1:0] slot;

        n_phase   = r_phase;
        n_status  = r_status;
        n_count   = r_count;
        n_cur     = r_cur;
        n_created = r_created;
        n_bypass  = r_bypass;
        mem_we    = 1'b0;
        mem_waddr = cs;
        mem_wdata = i_op.sp;
        mem_re    = 1'b0;
        mem_raddr = cs;
        res_push  = 1'b0;
        res_val.next_sp      = '0;
        res_val.running_task = RUN_W'(r_cur);
        res_val.accepted     = 1'b1;
        dem   = r_status;
        found = 1'b0;
        pick  = cs;
        sum   = '0;
        slot  = '0;

        if (r_phase == PH_READ) begin
            res_push             = 1'b1;
            res_val.next_sp      = r_bypass ? r_sp_hold : r_rd_data;
            res_val.running_task = RUN_W'(r_cur);
            n_phase              = PH_RUN;
        end else if (o_op_take) begin
            if (i_op.is_tick) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_status[i] == TS_BLOCKED && r_count[i] != '0) begin
                        n_count[i] = r_count[i] - DATA_W'(1);
                        if (r_count[i] == DATA_W'(1)) begin
                            n_status[i] = TS_READY;
                        end
                    end
                end
                res_push = 1'b1;
            end else if (i_op.is_delay) begin
                if (i_op.ticks_nonzero && started) begin
                    n_status[cs] = TS_BLOCKED;
                    n_count[cs]  = i_op.ticks;
                end else begin
                    res_val.accepted = 1'b0;
                end
                res_push = 1'b1;
            end else if (i_op.is_create) begin
                if (r_created < CRT_W'(USER_TASKS)) begin
                    slot          = SLOT_W'(r_created) + SLOT_W'(1);
                    n_created     = r_created + CRT_W'(1);
                    n_status[slot] = TS_READY;
                    n_count[slot]  = '0;
                    mem_we        = 1'b1;
                    mem_waddr     = slot;
                end else begin
                    res_val.accepted = 1'b0;
                end
                res_push = 1'b1;
            end else if (i_op.is_switch && !started) begin
                // First switch starts the idle task with the configured pointer.
                n_cur                = '0;
                n_status[0]          = TS_RUNNING;
                res_val.next_sp      = r_idle_sp;
                res_val.running_task = '0;
                res_push             = 1'b1;
            end else if (i_op.is_switch) begin
                if (dem[cs] == TS_RUNNING) begin
                    dem[cs] = TS_READY;
                end
                for (int k = 1; k < SLOTS; k++) begin
                    sum = {1'b0, cs} + (SLOT_W+1)'(k);
                    if (sum >= (SLOT_W+1)'(SLOTS)) begin
                        sum = sum - (SLOT_W+1)'(SLOTS);
                    end
                    if (!found && dem[sum[SLOT_W-1:0]] == TS_READY) begin
                        found = 1'b1;
                        pick  = sum[SLOT_W-1:0];
                    end
                end
                if (!found) begin
                    pick = (dem[cs] == TS_READY) ? cs : '0;
                end
                n_status = dem;
                if (dem[pick] == TS_READY) begin
                    n_status[pick] = TS_RUNNING;
                end
                mem_we    = 1'b1;
                mem_waddr = cs;
                mem_re    = 1'b1;
                mem_raddr = pick;
                n_bypass  = (pick == cs);
                n_cur     = CUR_W'(pick);
                n_phase   = PH_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_spmem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_spmem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_wptr] <= res_val;
        end
        if (o_op_take) begin
            r_sp_hold <= i_op.sp;
        end
        r_bypass <= n_bypass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RUN;
            r_cur     <= NONE_STARTED;
            r_created <= '0;
            r_idle_sp <= '0;
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_rcnt    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= (i == 0) ? TS_READY : TS_UNUSED;
                r_count[i]  <= '0;
            end
        end else begin
            r_phase   <= n_phase;
            r_cur     <= n_cur;
            r_created <= n_created;
            r_status  <= n_status;
            r_count   <= n_count;
            if (i_cfg_we) begin
                r_idle_sp <= i_cfg_wdata;
            end
            if (res_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            r_rcnt <= r_rcnt + Q_CNT_W'(res_push) - Q_CNT_W'(pop_ok);
        end
    end

endmodule

// File: hw/rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: front end, back end and their queue.
//
// The scheduler looks like a queue on both sides: a command item goes in with push while
// full is low, and one result item per command comes out, oldest first, read with pop
// while empty is low. A command first lands in a two-entry command queue in the front
// end, where it is classified; the back end then executes it. Tick, delay and create
// sustain one item per cycle while the result queue has room. A switch adds a read phase,
// taking no new command, that pushes the saved stack pointer of the task chosen by the
// round-robin search, read from the saved-pointer memory. On the way to the outputs a
// command is registered in both queues, a switch also in its read phase, and it waits
// while the two-entry result queue is full. The idle task's initial stack pointer is
// written through i_cfg_we and i_cfg_wdata; the user must do so while the scheduler is
// idle, which the block does not enforce. The very first switch hands it out. Task slots
// come up after reset with the idle slot ready and every user slot unused; there is no
// clearing pass, so the scheduler takes commands from the first cycle after reset.
module round_robin_task_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_cmd,
    input  logic [rrts_pkg::DATA_W-1:0] i_delay_ticks,
    input  logic [rrts_pkg::DATA_W-1:0] i_stack_pointer,
    output logic                        empty,
    input  logic                        pop,
    output logic [rrts_pkg::DATA_W-1:0] o_next_stack_pointer,
    output logic [rrts_pkg::RUN_W-1:0]  o_running_task,
    output logic                        o_accepted,
    input  logic                        i_cfg_we,
    input  logic [rrts_pkg::DATA_W-1:0] i_cfg_wdata
);
    import rrts_pkg::*;

    logic op_valid;
    logic op_take;
    t_op  op;
    t_res res;

    // The front end only buffers and classifies; all task state lives in the back end.
    rrts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_cmd           (i_cmd),
        .i_delay_ticks   (i_delay_ticks),
        .i_stack_pointer (i_stack_pointer),
        .o_op_valid      (op_valid),
        .o_op            (op),
        .i_op_take       (op_take)
    );

    // The back end pulls a command only when its result queue has room, so a result
    // is never dropped while the consumer stalls.
    rrts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_take   (op_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_next_stack_pointer = res.next_sp;
    assign o_running_task       = res.running_task;
    assign o_accepted           = res.accepted;

endmodule

// File: hw/rtl/rrts_checker.sv
// Port-level assertions for the round-robin task scheduler and their bind.
module rrts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [rrts_pkg::DATA_W-1:0] o_next_stack_pointer,
    input logic [rrts_pkg::RUN_W-1:0]  o_running_task,
    input logic                        o_accepted
);
    import rrts_pkg::*;

    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // An ignored command never hands out a stack pointer.
    a_ignored_no_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_accepted) |-> (o_next_stack_pointer == '0))
        else $error("ignored command returned a stack pointer");

    // The running slot is a real slot or the none-started marker.
    a_running_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_running_task <= RUN_W'(NONE_STARTED)))
        else $error("running task out of range");

    // A waiting result holds while the consumer stalls.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_next_stack_pointer) &&
                              $stable(o_running_task) && $stable(o_accepted)))
        else $error("stalled result changed");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);
